### hdl/gcr_sf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables for the GCR sector formatter.
// No dependencies; imported by gcr_sector_formatter.
package gcr_sf_pkg;

    // request kinds
    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_EMIT  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VOLUME       = 2'd0;
    localparam logic [1:0] CFG_SYNC_FIRST   = 2'd1;
    localparam logic [1:0] CFG_SYNC_BETWEEN = 2'd2;

    localparam logic [7:0] RST_VOLUME       = 8'd254;
    localparam logic [7:0] RST_SYNC_FIRST   = 8'd128;
    localparam logic [7:0] RST_SYNC_BETWEEN = 8'd20;

    // stream layout, positions counted after the sync run
    localparam logic [9:0] FIELD_LEN    = 10'd368;
    localparam logic [9:0] Q_ADDR_FIELD = 10'd3;
    localparam logic [9:0] Q_ADDR_EPI   = 10'd11;
    localparam logic [9:0] Q_GAP        = 10'd14;
    localparam logic [9:0] Q_DATA_PRO   = 10'd19;
    localparam logic [9:0] Q_PAYLOAD    = 10'd22;
    localparam logic [9:0] Q_CHECKSUM   = 10'd364;
    localparam logic [9:0] Q_DATA_EPI   = 10'd365;
    localparam logic [9:0] AUX_COUNT    = 10'd86;
    localparam logic [9:0] AUX_FULL     = 10'd84;

    // marks
    localparam logic [7:0] C_SYNC      = 8'hFF;
    localparam logic [7:0] C_PRO0      = 8'hD5;
    localparam logic [7:0] C_PRO1      = 8'hAA;
    localparam logic [7:0] C_ADDR_PRO2 = 8'h96;
    localparam logic [7:0] C_DATA_PRO2 = 8'hAD;
    localparam logic [7:0] C_EPI0      = 8'hDE;
    localparam logic [7:0] C_EPI1      = 8'hAA;
    localparam logic [7:0] C_EPI2      = 8'hEB;
    localparam logic [7:0] C_ODD_MASK  = 8'h55;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [5:0] track;
        logic [3:0] physical_sector;
    } t_in_item;

    typedef struct packed {
        logic [7:0] nibble;
        logic       last;
        logic [3:0] logical_sector;
        logic       status;
    } t_out_item;

    // microcode
    typedef logic [2:0] t_step;
    localparam t_step ST_IDLE = 3'd0;
    localparam t_step ST_AUX0 = 3'd1;
    localparam t_step ST_AUX1 = 3'd2;
    localparam t_step ST_AUX2 = 3'd3;
    localparam t_step ST_AUX3 = 3'd4;
    localparam t_step ST_UP0  = 3'd5;
    localparam t_step ST_UP1  = 3'd6;
    localparam t_step ST_OUT  = 3'd7;

    typedef enum logic [1:0] {
        ADR_K    = 2'd0,
        ADR_K86  = 2'd1,
        ADR_K172 = 2'd2,
        ADR_KM86 = 2'd3
    } t_addr_sel;

    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_P0   = 3'd1,
        CAP_P1   = 3'd2,
        CAP_P2   = 3'd3,
        CAP_UP   = 3'd4
    } t_cap;

    typedef enum logic {
        JMP_NONE   = 1'b0,
        JMP_K_GE84 = 1'b1
    } t_jmp;

    typedef struct packed {
        t_addr_sel addr_sel;
        t_cap      cap;
        t_jmp      jmp;
        t_step     jmp_to;
        t_step     next;
        logic      finish;
    } t_uword;

    function automatic t_uword f_urom(input t_step s);
        t_uword w;
        w = '{ADR_K, CAP_NONE, JMP_NONE, ST_IDLE, ST_IDLE, 1'b0};
        case (s)
            ST_AUX0: w = '{ADR_K,    CAP_NONE, JMP_NONE,   ST_IDLE, ST_AUX1, 1'b0};
            ST_AUX1: w = '{ADR_K86,  CAP_P0,   JMP_NONE,   ST_IDLE, ST_AUX2, 1'b0};
            ST_AUX2: w = '{ADR_K172, CAP_P1,   JMP_K_GE84, ST_OUT,  ST_AUX3, 1'b0};
            ST_AUX3: w = '{ADR_K,    CAP_P2,   JMP_NONE,   ST_IDLE, ST_OUT,  1'b0};
            ST_UP0:  w = '{ADR_KM86, CAP_NONE, JMP_NONE,   ST_IDLE, ST_UP1,  1'b0};
            ST_UP1:  w = '{ADR_K,    CAP_UP,   JMP_NONE,   ST_IDLE, ST_OUT,  1'b0};
            ST_OUT:  w = '{ADR_K,    CAP_NONE, JMP_NONE,   ST_IDLE, ST_IDLE, 1'b1};
            default: w = '{ADR_K,    CAP_NONE, JMP_NONE,   ST_IDLE, ST_IDLE, 1'b0};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] f_interleave(input logic [3:0] s);
        logic [3:0] r;
        case (s)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd7;
            4'd2:    r = 4'd14;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd13;
            4'd5:    r = 4'd5;
            4'd6:    r = 4'd12;
            4'd7:    r = 4'd4;
            4'd8:    r = 4'd11;
            4'd9:    r = 4'd3;
            4'd10:   r = 4'd10;
            4'd11:   r = 4'd2;
            4'd12:   r = 4'd9;
            4'd13:   r = 4'd1;
            4'd14:   r = 4'd8;
            default: r = 4'd15;
        endcase
        return r;
    endfunction

    localparam logic [7:0] GCR_TABLE [64] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    function automatic logic [7:0] f_gcr(input logic [5:0] v);
        return GCR_TABLE[v];
    endfunction

    // 4-and-4: odd half keeps the even-numbered bits, even half the odd-numbered ones shifted down
    function automatic logic [7:0] f_code44(input logic [7:0] v, input logic odd_half);
        logic [7:0] r;
        if (odd_half) begin
            r = (v & C_ODD_MASK) | C_PRO1;
        end else begin
            r = ((v >> 1) & C_ODD_MASK) | C_PRO1;
        end
        return r;
    endfunction

    function automatic logic [1:0] f_swap2(input logic [1:0] b);
        return {b[0], b[1]};
    endfunction

endpackage

### hdl/gcr_sector_formatter.sv
`timescale 1ns / 1ps
// GCR sector formatter: one sector as a 4-and-4 / 6-and-2 nibble stream.
// Depends on gcr_sf_pkg.
//
// Use:
//  - Input channel (i_in_valid / o_in_stall / i_in_data) takes requests:
//    begin latches track and physical sector and answers with the logical
//    sector to load; load writes the next of 256 data bytes (no answer);
//    emit answers with the next disk nibble, or status 1 when the buffer
//    is not full yet or the sector is already done.
//  - Output channel (o_out_valid / i_out_stall / o_out_data) carries one
//    answer per begin or emit, from an output register.
//  - Config channel (i_cfg_valid / o_cfg_ready) is always ready; write it
//    only between requests.
// Timing: begin, load, sync/header/trailer emits: answer in the cycle after
//  accept, next request may follow at once. Emits in the data payload read
//  the sector buffer through its single read port under a microcoded step
//  sequence: aux values pass through steps AUX0 to AUX3 and OUT (the last
//  two skip AUX3), upper six-bit values through UP0, UP1 and OUT; the input
//  stays stalled until that answer is registered.
// The input stalls while the output register holds an answer that the
//  receiver is stalling. Reset (synchronous, active low) restores the
//  config defaults and clears counters; buffer contents are not cleared.
module gcr_sector_formatter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  gcr_sf_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output gcr_sf_pkg::t_out_item o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [7:0]            i_cfg_data
);
    import gcr_sf_pkg::*;

    // config
    logic [7:0] r_volume, r_sync_first, r_sync_between;

    // sector state
    logic [7:0] r_mem [256];
    logic [7:0] r_rd_data;
    logic [8:0] r_load_cnt;
    logic [9:0] r_pos;
    logic [5:0] r_roll;
    logic [5:0] r_lat_track;
    logic [3:0] r_lat_sector;

    // sequencer
    t_step  r_step;
    t_uword cw;
    logic [5:0] r_v;

    logic      r_out_valid;
    t_out_item r_out;

    // position decode
    logic [7:0] sync_cnt;
    logic [9:0] end_pos, q, q3, k, epi_idx;
    logic       emit_err, is_last;
    logic [7:0] hdr_v, direct_nib;
    logic       need_aux, need_up;
    logic [7:0] rd_addr;
    logic       in_acc, busy;
    t_step      n_step;
    logic       n_out_valid;

    assign busy        = (r_step != ST_IDLE);
    assign o_in_stall  = busy || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign cw          = f_urom(r_step);

    always_comb begin
        sync_cnt = (r_lat_sector == 4'd0) ? r_sync_first : r_sync_between;
        end_pos  = {2'b00, sync_cnt} + FIELD_LEN;
        q        = r_pos - {2'b00, sync_cnt};
        q3       = q - Q_ADDR_FIELD;
        k        = q - Q_PAYLOAD;
        epi_idx  = q - Q_DATA_EPI;
        emit_err = !r_load_cnt[8] || (r_pos >= end_pos);
        is_last  = ((r_pos + 10'd1) == end_pos);

        case (q3[2:1])
            2'd0:    hdr_v = r_volume;
            2'd1:    hdr_v = {2'b00, r_lat_track};
            2'd2:    hdr_v = {4'b0000, r_lat_sector};
            default: hdr_v = r_volume ^ {2'b00, r_lat_track} ^ {4'b0000, r_lat_sector};
        endcase

        need_aux   = 1'b0;
        need_up    = 1'b0;
        direct_nib = C_SYNC;
        if (r_pos < {2'b00, sync_cnt}) begin
            direct_nib = C_SYNC;
        end else if (q < Q_ADDR_FIELD) begin
            case (q[1:0])
                2'd0:    direct_nib = C_PRO0;
                2'd1:    direct_nib = C_PRO1;
                default: direct_nib = C_ADDR_PRO2;
            endcase
        end else if (q < Q_ADDR_EPI) begin
            direct_nib = f_code44(hdr_v, q3[0]);
        end else if (q < Q_GAP) begin
            case (q - Q_ADDR_EPI)
                10'd0:   direct_nib = C_EPI0;
                10'd1:   direct_nib = C_EPI1;
                default: direct_nib = C_EPI2;
            endcase
        end else if (q < Q_DATA_PRO) begin
            direct_nib = C_SYNC;
        end else if (q < Q_PAYLOAD) begin
            case (q - Q_DATA_PRO)
                10'd0:   direct_nib = C_PRO0;
                10'd1:   direct_nib = C_PRO1;
                default: direct_nib = C_DATA_PRO2;
            endcase
        end else if (q < Q_CHECKSUM) begin
            need_aux = (k < AUX_COUNT);
            need_up  = (k >= AUX_COUNT);
        end else if (q == Q_CHECKSUM) begin
            direct_nib = f_gcr(r_roll);
        end else begin
            case (epi_idx[1:0])
                2'd0:    direct_nib = C_EPI0;
                2'd1:    direct_nib = C_EPI1;
                default: direct_nib = C_EPI2;
            endcase
        end

        case (cw.addr_sel)
            ADR_K:    rd_addr = k[7:0];
            ADR_K86:  rd_addr = k[7:0] + 8'd86;
            ADR_K172: rd_addr = k[7:0] + 8'd172;
            ADR_KM86: rd_addr = k[7:0] - 8'd86;
            default:  rd_addr = k[7:0];
        endcase

        if (cw.jmp == JMP_K_GE84 && k >= AUX_FULL) begin
            n_step = cw.jmp_to;
        end else begin
            n_step = cw.next;
        end

        // answer register: loaded by the last microstep, a begin, a refused
        // emit or a direct emit; otherwise held while the receiver stalls
        n_out_valid = r_out_valid && i_out_stall;
        if (cw.finish) begin
            n_out_valid = 1'b1;
        end else if (in_acc && i_in_data.kind == KIND_BEGIN) begin
            n_out_valid = 1'b1;
        end else if (in_acc && i_in_data.kind == KIND_EMIT && (emit_err || !(need_aux || need_up))) begin
            n_out_valid = 1'b1;
        end
    end

    // sector buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.kind == KIND_LOAD && !r_load_cnt[8]) begin
            r_mem[r_load_cnt[7:0]] <= i_in_data.data_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // payload value assembly
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_v <= 6'd0;
        end else begin
            case (cw.cap)
                CAP_P0:  r_v[1:0] <= f_swap2(r_rd_data[1:0]);
                CAP_P1:  r_v[3:2] <= f_swap2(r_rd_data[1:0]);
                CAP_P2:  r_v[5:4] <= f_swap2(r_rd_data[1:0]);
                CAP_UP:  r_v      <= r_rd_data[7:2];
                default: r_v      <= r_v;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (cw.finish) begin
            r_out <= '{f_gcr(r_v ^ r_roll), is_last, f_interleave(r_lat_sector), 1'b0};
        end else if (in_acc && i_in_data.kind == KIND_BEGIN) begin
            r_out <= '{8'd0, 1'b0, f_interleave(i_in_data.physical_sector), 1'b0};
        end else if (in_acc && i_in_data.kind == KIND_EMIT) begin
            if (emit_err) begin
                r_out <= '{8'd0, 1'b0, f_interleave(r_lat_sector), 1'b1};
            end else begin
                r_out <= '{direct_nib, is_last, f_interleave(r_lat_sector), 1'b0};
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume       <= RST_VOLUME;
            r_sync_first   <= RST_SYNC_FIRST;
            r_sync_between <= RST_SYNC_BETWEEN;
            r_load_cnt     <= '0;
            r_pos          <= '0;
            r_roll         <= '0;
            r_lat_track    <= '0;
            r_lat_sector   <= '0;
            r_step         <= ST_IDLE;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VOLUME:       r_volume       <= i_cfg_data;
                    CFG_SYNC_FIRST:   r_sync_first   <= i_cfg_data;
                    CFG_SYNC_BETWEEN: r_sync_between <= i_cfg_data;
                    default:          ;
                endcase
            end

            r_out_valid <= n_out_valid;

            if (busy) begin
                r_step <= n_step;
                if (cw.finish) begin
                    r_roll <= r_v;
                    r_pos  <= r_pos + 10'd1;
                end
            end else if (in_acc) begin
                case (i_in_data.kind)
                    KIND_BEGIN: begin
                        r_lat_track  <= i_in_data.track;
                        r_lat_sector <= i_in_data.physical_sector;
                        r_load_cnt   <= '0;
                        r_pos        <= '0;
                        r_roll       <= '0;
                    end
                    KIND_LOAD: begin
                        if (!r_load_cnt[8]) begin
                            r_load_cnt <= r_load_cnt + 9'd1;
                        end
                    end
                    KIND_EMIT: begin
                        if (!emit_err) begin
                            if (need_aux) begin
                                r_step <= ST_AUX0;
                            end else if (need_up) begin
                                r_step <= ST_UP0;
                            end else begin
                                r_pos <= r_pos + 10'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // checks
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_in_stall)
        else $error("request accepted while sequencer busy");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_OUT) |-> !r_out_valid)
        else $error("payload result would overwrite a pending answer");

    a_load_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt[8] |-> (r_load_cnt[7:0] == 8'd0))
        else $error("load count past sector size");

    a_aux_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_AUX3) |-> ($past(r_step) == ST_AUX2))
        else $error("third aux pair captured out of order");

endmodule
